/* rtl/core/pls_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types, widths and word conversion helpers for the positional list.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 32;

    localparam int CMD_W   = 3;
    localparam int POS_W   = 6;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 32;
    localparam int LEN_W   = 5;
    localparam int ERR_W   = 2;

    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    // signed width wide enough for count plus a negative position
    localparam int SUM_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK       = 2'd0,
        ERR_POSITION = 2'd1,
        ERR_FULL     = 2'd2,
        ERR_EMPTY    = 2'd3
    } err_t;

    // update broadcast to every cell
    typedef struct packed {
        logic             shift_up;
        logic             shift_down;
        logic [IDX_W-1:0] idx;
    } op_t;

    // outcome of one command as seen by the output stage
    typedef struct packed {
        err_t             err;
        logic [CNT_W-1:0] cnt_next;
        logic             rd_ok;
        logic [IDX_W-1:0] idx;
    } res_t;

    function automatic logic [WORD_WIDTH-1:0] to_entry(input logic [IN_W-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[WORD_WIDTH-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] to_out_word(input logic [WORD_WIDTH-1:0] w);
        logic [63:0] t;
        t = 64'(w);
        return t[OUT_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] to_length(input logic [CNT_W-1:0] c);
        logic [63:0] t;
        t = 64'(c);
        return t[LEN_W-1:0];
    endfunction

endpackage

/* rtl/core/pls_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_req_if / pls_rsp_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface pls_req_if;
    logic                              valid;
    logic                              ready;
    logic [pls_pkg::CMD_W-1:0]         cmd;
    logic signed [pls_pkg::POS_W-1:0]  position;
    logic [pls_pkg::IN_W-1:0]          value;

    modport source (output valid, output cmd, output position, output value, input ready);
    modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface pls_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [pls_pkg::OUT_W-1:0]  read_word;
    logic [pls_pkg::LEN_W-1:0]  length;
    logic [pls_pkg::ERR_W-1:0]  error;

    modport source (output valid, output read_word, output length, output error, input ready);
    modport sink   (input valid, input read_word, input length, input error, output ready);
endinterface

/* rtl/core/pls_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_cell
// One list slot: keep its word, take a neighbor's word, or take the new word.
// ----------------------------------------------------------------------------
module pls_cell
(
    input  logic                           clk,
    input  pls_pkg::op_t                   op,
    input  logic [pls_pkg::IDX_W-1:0]      my_idx,
    input  logic [pls_pkg::WORD_WIDTH-1:0] new_word,
    input  logic [pls_pkg::WORD_WIDTH-1:0] left_word,
    input  logic [pls_pkg::WORD_WIDTH-1:0] right_word,
    output logic [pls_pkg::WORD_WIDTH-1:0] word
);

    logic [pls_pkg::WORD_WIDTH-1:0] word_reg;
    logic [pls_pkg::WORD_WIDTH-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (op.shift_up)
        begin
            if (my_idx == op.idx)
                word_next = new_word;
            else if (my_idx > op.idx)
                word_next = left_word;
        end
        else if (op.shift_down && (my_idx >= op.idx))
        begin
            word_next = right_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

/* rtl/core/pls_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_ctrl
// Length register, position resolution and command checks for the list.
// ----------------------------------------------------------------------------
module pls_ctrl
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic [pls_pkg::CMD_W-1:0]        cmd,
    input  logic signed [pls_pkg::POS_W-1:0] position,
    output pls_pkg::op_t                     op,
    output pls_pkg::res_t                    res
);

    logic [pls_pkg::CNT_W-1:0]        count_reg;
    logic [pls_pkg::CNT_W-1:0]        count_next;
    logic signed [pls_pkg::SUM_W-1:0] pos_ext;
    logic signed [pls_pkg::SUM_W-1:0] cnt_ext;
    logic signed [pls_pkg::SUM_W-1:0] eff;
    logic                             ok_ins;
    logic                             ok_acc;
    logic                             full;
    logic                             empty;
    logic [pls_pkg::IDX_W-1:0]        eff_idx;
    logic [pls_pkg::IDX_W-1:0]        tail_idx;

    always_comb
    begin
        pos_ext = pls_pkg::SUM_W'(position);
        cnt_ext = $signed(pls_pkg::SUM_W'(count_reg));
        // a negative position counts back from the length
        eff     = (position < 0) ? (cnt_ext + pos_ext) : pos_ext;
        ok_ins  = (eff >= 0) && (eff <= cnt_ext);
        ok_acc  = (eff >= 0) && (eff < cnt_ext);
        full    = (count_reg == pls_pkg::CNT_W'(pls_pkg::DEPTH));
        empty   = (count_reg == '0);
        eff_idx  = eff[pls_pkg::IDX_W-1:0];
        tail_idx = count_reg[pls_pkg::IDX_W-1:0];
    end

    always_comb
    begin
        op             = '0;
        res.err        = pls_pkg::ERR_OK;
        res.rd_ok      = 1'b0;
        res.idx        = eff_idx;
        count_next     = count_reg;
        case (cmd)
            pls_pkg::CMD_CLEAR:
            begin
                count_next = '0;
            end
            pls_pkg::CMD_APPEND:
            begin
                if (full)
                    res.err = pls_pkg::ERR_FULL;
                else
                begin
                    // append is an insert at the tail
                    op.shift_up = 1'b1;
                    op.idx      = tail_idx;
                    count_next  = count_reg + 1'b1;
                end
            end
            pls_pkg::CMD_INSERT:
            begin
                if (!ok_ins)
                    res.err = pls_pkg::ERR_POSITION;
                else if (full)
                    res.err = pls_pkg::ERR_FULL;
                else
                begin
                    op.shift_up = 1'b1;
                    op.idx      = eff_idx;
                    count_next  = count_reg + 1'b1;
                end
            end
            pls_pkg::CMD_REMOVE:
            begin
                if (empty)
                    res.err = pls_pkg::ERR_EMPTY;
                else if (!ok_acc)
                    res.err = pls_pkg::ERR_POSITION;
                else
                begin
                    op.shift_down = 1'b1;
                    op.idx        = eff_idx;
                    count_next    = count_reg - 1'b1;
                end
            end
            pls_pkg::CMD_READ:
            begin
                if (!ok_acc)
                    res.err = pls_pkg::ERR_POSITION;
                else
                    res.rd_ok = 1'b1;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        // cells only move on an accepted word
        if (!accept)
        begin
            op.shift_up   = 1'b0;
            op.shift_down = 1'b0;
        end
        res.cnt_next = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (accept)
            count_reg <= count_next;
    end

endmodule

/* rtl/core/positional_list_store_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store_unit
// Bounded ordered list of words held in a row of shifting cells.
// The result word is registered and becomes valid in the cycle after the command is accepted.
// Throughput: one command per cycle while no stalled result is held; every cell updates in the accept cycle.
// A stalled result holds the command port only while the result register is full.
// Reset clears the length and the result valid; entry contents stay undefined.
// ----------------------------------------------------------------------------
module positional_list_store_unit
(
    input  logic    clk,
    input  logic    rst_n,
    pls_req_if.sink   req,
    pls_rsp_if.source rsp
);

    logic                           accept;
    pls_pkg::op_t                   op;
    pls_pkg::res_t                  res;
    logic [pls_pkg::WORD_WIDTH-1:0] new_word;
    logic [pls_pkg::WORD_WIDTH-1:0] cell_word [pls_pkg::DEPTH];
    logic [pls_pkg::WORD_WIDTH-1:0] sel_word;

    logic                           valid_reg;
    logic [pls_pkg::OUT_W-1:0]      read_word_reg;
    logic [pls_pkg::LEN_W-1:0]      length_reg;
    logic [pls_pkg::ERR_W-1:0]      error_reg;

    assign req.ready = !valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign new_word  = pls_pkg::to_entry(req.value);

    pls_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .cmd      (req.cmd),
        .position (req.position),
        .op       (op),
        .res      (res)
    );

    for (genvar i = 0; i < pls_pkg::DEPTH; i++)
    begin : g_cell
        logic [pls_pkg::WORD_WIDTH-1:0] left_w;
        logic [pls_pkg::WORD_WIDTH-1:0] right_w;

        // edge cells never use the missing neighbor
        assign left_w  = (i == 0) ? new_word : cell_word[(i == 0) ? 0 : i - 1];
        assign right_w = (i == pls_pkg::DEPTH - 1) ? cell_word[i]
                       : cell_word[(i == pls_pkg::DEPTH - 1) ? i : i + 1];

        pls_cell u_cell
        (
            .clk        (clk),
            .op         (op),
            .my_idx     (pls_pkg::IDX_W'(i)),
            .new_word   (new_word),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_word[i])
        );
    end

    always_comb
    begin
        sel_word = '0;
        for (int k = 0; k < pls_pkg::DEPTH; k++)
        begin
            if (res.idx == pls_pkg::IDX_W'(k))
                sel_word = sel_word | cell_word[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (rsp.ready)
            valid_reg <= 1'b0;
    end

    // result payload, loaded on accept and held while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_word_reg <= res.rd_ok ? pls_pkg::to_out_word(sel_word) : '0;
            length_reg    <= pls_pkg::to_length(res.cnt_next);
            error_reg     <= res.err;
        end
    end

    assign rsp.valid     = valid_reg;
    assign rsp.read_word = read_word_reg;
    assign rsp.length    = length_reg;
    assign rsp.error     = error_reg;

endmodule

/* test/positional_list_store_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store_unit_tb
// Drives command words into the positional list and checks every result word
// against a local model of the list. A short table covers the empty and full
// list, the position limits, two of the unused commands and clear. A long run of
// random commands then moves the list between growing and shrinking phases.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module positional_list_store_unit_tb;

    import pls_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NOP_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_NOP_7 = 3'd7;

    localparam logic signed [POS_W-1:0] POS_MIN = 6'b100000;
    localparam logic signed [POS_W-1:0] POS_MAX = 6'sd31;

    localparam int RANDOM_COMMANDS = 1600;
    localparam int STALL_LIMIT     = 2000;

    typedef struct packed {
        logic [OUT_W-1:0] read_word;
        logic [LEN_W-1:0] length;
        err_t             error;
    } list_result_t;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [POS_W-1:0]  position;
        logic [IN_W-1:0]          value;
        int                       reps;
        bit                       typed;
        logic [OUT_W-1:0]         read_word;
        logic [LEN_W-1:0]         length;
        err_t                     error;
    } stim_row_t;

    localparam int N_ROWS = 27;

    stim_row_t directed_rows [N_ROWS] = '{
        '{CMD_READ,   6'sd0,    32'h0,         1,  1'b1, 32'h0, 5'd0,  ERR_POSITION},
        '{CMD_REMOVE, 6'sd0,    32'h0,         1,  1'b1, 32'h0, 5'd0,  ERR_EMPTY},
        '{CMD_REMOVE, POS_MIN,  32'h0,         1,  1'b1, 32'h0, 5'd0,  ERR_EMPTY},
        '{CMD_INSERT, 6'sd1,    32'h1234_5678, 1,  1'b1, 32'h0, 5'd0,  ERR_POSITION},
        '{CMD_INSERT, 6'sd0,    32'hFFFF_FFFF, 1,  1'b1, 32'h0, 5'd1,  ERR_OK},
        '{CMD_APPEND, POS_MAX,  32'h0,         1,  1'b1, 32'h0, 5'd2,  ERR_OK},
        '{CMD_INSERT, -6'sd2,   32'hA5A5_A5A5, 1,  1'b0, 32'h0, 5'd0,  ERR_OK},
        '{CMD_INSERT, 6'sd3,    32'h5A5A_5A5A, 1,  1'b0, 32'h0, 5'd0,  ERR_OK},
        '{CMD_READ,   -6'sd1,   32'h0,         1,  1'b0, 32'h0, 5'd0,  ERR_OK},
        '{CMD_READ,   -6'sd4,   32'h0,         1,  1'b0, 32'h0, 5'd0,  ERR_OK},
        '{CMD_READ,   -6'sd5,   32'h0,         1,  1'b1, 32'h0, 5'd4,  ERR_POSITION},
        '{CMD_READ,   6'sd4,    32'h0,         1,  1'b1, 32'h0, 5'd4,  ERR_POSITION},
        '{CMD_REMOVE, -6'sd1,   32'h0,         1,  1'b0, 32'h0, 5'd0,  ERR_OK},
        '{CMD_REMOVE, 6'sd3,    32'h0,         1,  1'b1, 32'h0, 5'd3,  ERR_POSITION},
        '{CMD_NOP_5,  -6'sd1,   32'hFFFF_FFFF, 1,  1'b1, 32'h0, 5'd3,  ERR_OK},
        '{CMD_NOP_7,  POS_MIN,  32'hFFFF_FFFF, 1,  1'b1, 32'h0, 5'd3,  ERR_OK},
        '{CMD_CLEAR,  6'sd0,    32'h0,         1,  1'b1, 32'h0, 5'd0,  ERR_OK},
        '{CMD_APPEND, 6'sd0,    32'h8000_0001, 16, 1'b0, 32'h0, 5'd0,  ERR_OK},
        '{CMD_APPEND, 6'sd0,    32'h0,         1,  1'b1, 32'h0, 5'd16, ERR_FULL},
        '{CMD_INSERT, 6'sd0,    32'h0,         1,  1'b1, 32'h0, 5'd16, ERR_FULL},
        '{CMD_INSERT, 6'sd17,   32'h0,         1,  1'b1, 32'h0, 5'd16, ERR_POSITION},
        '{CMD_INSERT, -6'sd17,  32'h0,         1,  1'b1, 32'h0, 5'd16, ERR_POSITION},
        '{CMD_INSERT, 6'sd16,   32'h0,         1,  1'b1, 32'h0, 5'd16, ERR_FULL},
        '{CMD_READ,   POS_MAX,  32'h0,         1,  1'b1, 32'h0, 5'd16, ERR_POSITION},
        '{CMD_READ,   -6'sd16,  32'h0,         1,  1'b0, 32'h0, 5'd0,  ERR_OK},
        '{CMD_REMOVE, -6'sd16,  32'h0,         1,  1'b0, 32'h0, 5'd0,  ERR_OK},
        '{CMD_READ,   6'sd15,   32'h0,         1,  1'b1, 32'h0, 5'd15, ERR_POSITION}
    };

    logic clk = 1'b0;
    logic rst_n;

    pls_req_if req_ch ();
    pls_rsp_if rsp_ch ();

    positional_list_store_unit dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // local copy of the list
    logic [WORD_WIDTH-1:0] list_words [DEPTH];
    int                    list_len = 0;

    list_result_t pending_replies [$];
    logic         typed_flag = 1'b0;
    list_result_t typed_result;

    int fault_count    = 0;
    int commands_sent  = 0;
    int results_seen   = 0;
    int quiet_cycles   = 0;
    int err_tally [4]  = '{0, 0, 0, 0};

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Map a signed position onto an entry; valid span is -len .. limit-1.
    function automatic bit locate_entry(input int pos, input int limit, output int idx);
        idx = 0;
        if (pos < 0)
        begin
            if (-pos > list_len)
                return 1'b0;
            idx = list_len + pos;
        end
        else if (pos >= limit)
        begin
            return 1'b0;
        end
        else
        begin
            idx = pos;
        end
        return 1'b1;
    endfunction

    function automatic list_result_t apply_list_command(input logic [CMD_W-1:0] cmd,
                                                        input logic signed [POS_W-1:0] position,
                                                        input logic [IN_W-1:0] value);
        list_result_t res;
        int           idx;
        int           pos;
        pos = position;
        res.read_word = '0;
        res.error     = ERR_OK;
        case (cmd)
            CMD_CLEAR:
            begin
                list_len = 0;
            end
            CMD_APPEND:
            begin
                if (list_len >= DEPTH)
                    res.error = ERR_FULL;
                else
                begin
                    list_words[list_len] = value[WORD_WIDTH-1:0];
                    list_len++;
                end
            end
            CMD_INSERT:
            begin
                if (!locate_entry(pos, list_len + 1, idx))
                    res.error = ERR_POSITION;
                else if (list_len >= DEPTH)
                    res.error = ERR_FULL;
                else
                begin
                    for (int i = list_len; i > idx; i--)
                        list_words[i] = list_words[i-1];
                    list_words[idx] = value[WORD_WIDTH-1:0];
                    list_len++;
                end
            end
            CMD_REMOVE:
            begin
                if (list_len == 0)
                    res.error = ERR_EMPTY;
                else if (!locate_entry(pos, list_len, idx))
                    res.error = ERR_POSITION;
                else
                begin
                    for (int i = idx + 1; i < list_len; i++)
                        list_words[i-1] = list_words[i];
                    list_len--;
                end
            end
            CMD_READ:
            begin
                if (!locate_entry(pos, list_len, idx))
                    res.error = ERR_POSITION;
                else
                    res.read_word = list_words[idx];
            end
            default:
            begin
            end
        endcase
        res.length = LEN_W'(list_len);
        return res;
    endfunction

    task automatic check_field(input string field, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (got !== want)
        begin
            fault_count++;
            $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
        end
    endtask

    // predict on every accepted command word, compare on every result word
    always @(posedge clk)
    begin : scoreboard
        list_result_t want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                want = apply_list_command(req_ch.cmd, req_ch.position, req_ch.value);
                if (typed_flag)
                    want = typed_result;
                pending_replies.push_back(want);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                err_tally[rsp_ch.error]++;
                if (pending_replies.size() == 0)
                begin
                    fault_count++;
                    $error("result word with no command outstanding");
                end
                else
                begin
                    want = pending_replies.pop_front();
                    check_field("read_word", want.read_word, rsp_ch.read_word);
                    check_field("length", OUT_W'(want.length), OUT_W'(rsp_ch.length));
                    check_field("error", OUT_W'(want.error), OUT_W'(rsp_ch.error));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("positional_list_store_unit_tb: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side: random stall before each word, with calm stretches
    initial
    begin : result_sink
        int stall;
        int calm;
        calm = 0;
        rsp_ch.ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (calm > 0)
            begin
                stall = 0;
                calm--;
            end
            else
            begin
                stall = $urandom_range(0, 9);
                if ($urandom_range(0, 19) == 0)
                    calm = $urandom_range(10, 40);
            end
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            @(negedge clk);
        end
    end

    int src_calm = 0;

    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic signed [POS_W-1:0] position,
                                input logic [IN_W-1:0] value,
                                input bit typed, input list_result_t res);
        int gap;
        if (src_calm > 0)
        begin
            gap = 0;
            src_calm--;
        end
        else
        begin
            gap = $urandom_range(0, 9);
            if ($urandom_range(0, 19) == 0)
                src_calm = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.cmd      <= cmd;
        req_ch.position <= position;
        req_ch.value    <= value;
        req_ch.valid    <= 1'b1;
        typed_flag      <= typed;
        typed_result    <= res;
        do @(posedge clk); while (!req_ch.ready);
        commands_sent++;
        @(negedge clk);
    endtask

    // mostly legal positions for the current length, some just outside, some anywhere
    function automatic logic signed [POS_W-1:0] pick_position(input logic [CMD_W-1:0] cmd);
        int roll;
        int top;
        roll = $urandom_range(0, 99);
        top  = (cmd == CMD_INSERT) ? list_len : list_len - 1;
        if (roll < 75 && top >= 0)
            return POS_W'(int'($urandom_range(0, top + list_len)) - list_len);
        else if (roll < 90)
            return ($urandom_range(0, 1) == 1) ? POS_W'(top + 1) : POS_W'(-list_len - 1);
        return POS_W'($urandom_range(0, 63));
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(input bit growing);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return CMD_CLEAR;
        if (roll < 8)
            return CMD_W'($urandom_range(CMD_NOP_5, CMD_NOP_7));
        if (growing)
        begin
            if (roll < 33) return CMD_APPEND;
            if (roll < 58) return CMD_INSERT;
            if (roll < 70) return CMD_REMOVE;
        end
        else
        begin
            if (roll < 16) return CMD_APPEND;
            if (roll < 26) return CMD_INSERT;
            if (roll < 66) return CMD_REMOVE;
        end
        return CMD_READ;
    endfunction

    function automatic logic [IN_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return $urandom;
    endfunction

    initial
    begin : command_source
        logic [CMD_W-1:0]        cmd;
        logic signed [POS_W-1:0] position;
        list_result_t            res;
        bit                      growing;
        int                      phase_left;

        req_ch.valid    = 1'b0;
        req_ch.cmd      = '0;
        req_ch.position = '0;
        req_ch.value    = '0;
        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[r])
        begin
            res.read_word = directed_rows[r].read_word;
            res.length    = directed_rows[r].length;
            res.error     = directed_rows[r].error;
            for (int k = 0; k < directed_rows[r].reps; k++)
                send_command(directed_rows[r].cmd, directed_rows[r].position,
                             directed_rows[r].value + IN_W'(k), directed_rows[r].typed, res);
        end

        growing    = 1'b1;
        phase_left = $urandom_range(20, 80);
        for (int n = 0; n < RANDOM_COMMANDS; n++)
        begin
            if (phase_left == 0)
            begin
                growing    = !growing;
                phase_left = $urandom_range(20, 80);
            end
            phase_left--;
            cmd = pick_command(growing);
            if (cmd == CMD_INSERT || cmd == CMD_REMOVE || cmd == CMD_READ)
                position = pick_position(cmd);
            else
                position = POS_W'($urandom_range(0, 63));
            send_command(cmd, position, pick_value(), 1'b0, res);
        end
        req_ch.valid <= 1'b0;

        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("ran %0d commands (%0d from the table), checked %0d result words",
                 commands_sent, commands_sent - RANDOM_COMMANDS, results_seen);
        $display("results by code: ok %0d, bad position %0d, full %0d, empty %0d",
                 err_tally[ERR_OK], err_tally[ERR_POSITION], err_tally[ERR_FULL],
                 err_tally[ERR_EMPTY]);
        if (fault_count == 0)
            $display("positional_list_store_unit_tb: PASS");
        else
            $display("positional_list_store_unit_tb: FAIL");
        $finish;
    end

endmodule
